>>> sv/hbfd_pkg.sv
package hbfd_pkg;

	localparam int DEF_MAX_WIDTH     = 256;
	localparam int DEF_MAX_CHAR_ROWS = 64;
	localparam int QUEUE_DEPTH       = 4;

	localparam logic [8:0] FRAME_WIDTH_RST = 9'd80;
	localparam logic [6:0] CHAR_ROWS_RST   = 7'd24;

	// register indexes
	localparam logic REG_FRAME_WIDTH = 1'b0;
	localparam logic REG_CHAR_ROWS   = 1'b1;

	// input operation codes
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_CLEAR   = 2'd1;
	localparam logic [1:0] OP_PRESENT = 2'd2;

	// queued command codes
	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_CLEAR   = 2'd1;
	localparam logic [1:0] CMD_PRESENT = 2'd2;

	// token kinds
	localparam logic [1:0] TOK_CELL = 2'd0;
	localparam logic [1:0] TOK_MOVE = 2'd1;
	localparam logic [1:0] TOK_DONE = 2'd2;

	typedef struct packed {
		logic [7:0]  pixel_color;
		logic [12:0] pos_y;
		logic [12:0] pos_x;
		logic [1:0]  operation;
	} in_item_t;

	typedef struct packed {
		logic [6:0] cursor_row;
		logic [7:0] bottom_color;
		logic [7:0] top_color;
		logic [7:0] skip_count;
		logic [1:0] token_kind;
	} token_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] color;
	} cmd_t;

	// effective frame size after clamping
	typedef struct packed {
		logic [8:0] width;
		logic [6:0] rows;
	} dims_t;

	function automatic int col_max(input int max_width);
		return (max_width < 256) ? max_width : 256;
	endfunction

	function automatic int row_max(input int max_rows);
		return (max_rows < 64) ? max_rows : 64;
	endfunction

	function automatic int col_bits(input int max_width);
		return (col_max(max_width) > 1) ? $clog2(col_max(max_width)) : 1;
	endfunction

	function automatic int row_bits(input int max_rows);
		return (row_max(max_rows) > 1) ? $clog2(row_max(max_rows)) : 1;
	endfunction

	function automatic int y_bits(input int max_rows);
		return $clog2(2 * row_max(max_rows));
	endfunction

endpackage

>>> sv/hbfd_queue.sv
module hbfd_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] head_data,
	output logic         empty
);
	import hbfd_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [W-1:0]  slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full      = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign head_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> sv/hbfd_front.sv
module hbfd_front #(
	parameter int MAX_WIDTH     = 256,
	parameter int MAX_CHAR_ROWS = 64,
	parameter int AW            = 15
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [39:0]    s_tdata,
	input  logic [1:0]     s_tuser,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_index,
	input  logic [8:0]     cfg_data,
	input  logic           init_busy,
	input  logic           q_full,
	output logic           push,
	output hbfd_pkg::cmd_t push_cmd,
	output logic [AW-1:0]  push_addr,
	output hbfd_pkg::dims_t dims
);
	import hbfd_pkg::*;

	localparam int         XW      = col_bits(MAX_WIDTH);
	localparam int         YW      = y_bits(MAX_CHAR_ROWS);
	localparam logic [8:0] COL_LIM = 9'(col_max(MAX_WIDTH));
	localparam logic [6:0] ROW_LIM = 7'(row_max(MAX_CHAR_ROWS));

	logic [8:0] frame_width_q;
	logic [6:0] char_rows_q;
	logic [8:0] w_clamp;
	logic [6:0] r_clamp;
	in_item_t   item;
	logic       in_range;
	logic       take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RST;
			char_rows_q   <= CHAR_ROWS_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_FRAME_WIDTH) frame_width_q <= cfg_data;
			else char_rows_q <= cfg_data[6:0];
		end
	end

	always_comb begin
		w_clamp = (frame_width_q > COL_LIM) ? COL_LIM : frame_width_q;
		r_clamp = (char_rows_q > ROW_LIM) ? ROW_LIM : char_rows_q;
		dims.width = (w_clamp == '0) ? 9'd1 : w_clamp;
		dims.rows  = (r_clamp == '0) ? 7'd1 : r_clamp;
	end

	assign item     = in_item_t'({s_tdata[33:0], s_tuser});
	assign s_tready = !init_busy && !q_full;
	assign take     = s_tvalid && s_tready;

	assign in_range = !item.pos_x[12] && (item.pos_x < 13'(dims.width)) &&
	                  !item.pos_y[12] && (item.pos_y < 13'({dims.rows, 1'b0}));

	// classify; drop out-of-frame writes and the unused code
	always_comb begin
		push           = 1'b0;
		push_cmd.kind  = CMD_WRITE;
		push_cmd.color = item.pixel_color;
		push_addr      = AW'({item.pos_y[YW-1:0], item.pos_x[XW-1:0]});
		case (item.operation)
			OP_WRITE: begin
				push = take && in_range;
			end
			OP_CLEAR: begin
				push          = take;
				push_cmd.kind = CMD_CLEAR;
			end
			OP_PRESENT: begin
				push          = take;
				push_cmd.kind = CMD_PRESENT;
			end
			default: push = 1'b0;
		endcase
	end

endmodule

>>> sv/hbfd_back.sv
module hbfd_back #(
	parameter int MAX_WIDTH     = 256,
	parameter int MAX_CHAR_ROWS = 64,
	parameter int AW            = 15
) (
	input  logic            clk,
	input  logic            arst_n,
	input  hbfd_pkg::dims_t dims,
	input  logic            q_empty,
	input  hbfd_pkg::cmd_t  q_cmd,
	input  logic [AW-1:0]   q_addr,
	output logic            pop,
	output logic            init_busy,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [31:0]     m_tdata,
	output logic [1:0]      m_tuser,
	output logic            m_tlast
);
	import hbfd_pkg::*;

	localparam int XW    = col_bits(MAX_WIDTH);
	localparam int RW    = row_bits(MAX_CHAR_ROWS);
	localparam int YW    = y_bits(MAX_CHAR_ROWS);
	localparam int DEPTH = 2 ** AW;

	localparam logic [3:0] ST_INIT   = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_CLEAR  = 4'd2;
	localparam logic [3:0] ST_CLRTOK = 4'd3;
	localparam logic [3:0] ST_TOP    = 4'd4;
	localparam logic [3:0] ST_BOT    = 4'd5;
	localparam logic [3:0] ST_CMP    = 4'd6;
	localparam logic [3:0] ST_ROWEND = 4'd7;
	localparam logic [3:0] ST_FRAME  = 4'd8;

	logic [7:0] mem_a [DEPTH];
	logic [7:0] mem_b [DEPTH];

	logic [3:0]    state_q;
	logic [AW-1:0] cnt_q;
	logic          draw_sel_q;
	logic [XW-1:0] scan_col_q;
	logic [RW-1:0] scan_row_q;
	logic [7:0]    run_q;
	logic          out_valid_q;
	token_t        out_tok_q;
	logic          out_last_q;
	logic [7:0]    rd_a_q;
	logic [7:0]    rd_b_q;
	logic [7:0]    top_d_q;
	logic [7:0]    top_o_q;

	logic          we_a;
	logic          we_b;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] addr_top;
	logic [AW-1:0] addr_bot;
	logic          emit;
	token_t        tok;
	logic          tok_last;
	logic          slot_free;
	logic [7:0]    bot_d;
	logic [7:0]    bot_o;
	logic          differ;
	logic [8:0]    col_next;
	logic          row_end;
	logic          last_row;
	logic [RW-1:0] row_clamp;

	assign init_busy = (state_q == ST_INIT);
	assign slot_free = !out_valid_q || m_tready;

	assign addr_top = AW'({YW'({scan_row_q, 1'b0}), scan_col_q});
	assign addr_bot = AW'({YW'({scan_row_q, 1'b1}), scan_col_q});

	assign bot_d    = draw_sel_q ? rd_a_q : rd_b_q;
	assign bot_o    = draw_sel_q ? rd_b_q : rd_a_q;
	assign differ   = (top_d_q != top_o_q) || (bot_d != bot_o);
	assign col_next = 9'(scan_col_q) + 9'd1;
	assign row_end  = (col_next >= dims.width);
	assign last_row = ((7'(scan_row_q) + 7'd1) >= dims.rows);
	// a row left beyond the frame after a shrink scans as the last row
	assign row_clamp = (7'(scan_row_q) >= dims.rows) ? RW'(dims.rows - 7'd1) : scan_row_q;

	always_comb begin
		pop      = 1'b0;
		we_a     = 1'b0;
		we_b     = 1'b0;
		wr_addr  = cnt_q;
		wr_data  = 8'd0;
		rd_addr  = addr_bot;
		emit     = 1'b0;
		tok      = '0;
		tok_last = 1'b0;
		case (state_q)
			ST_INIT: begin
				we_a = 1'b1;
				we_b = 1'b1;
			end
			ST_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (q_cmd.kind == CMD_WRITE) begin
						we_a    = draw_sel_q;
						we_b    = !draw_sel_q;
						wr_addr = q_addr;
						wr_data = q_cmd.color;
					end
				end
			end
			ST_CLEAR: begin
				we_a = draw_sel_q;
				we_b = !draw_sel_q;
			end
			ST_CLRTOK: begin
				emit           = 1'b1;
				tok.token_kind = TOK_MOVE;
				tok_last       = 1'b1;
			end
			ST_TOP: rd_addr = addr_top;
			ST_BOT: rd_addr = addr_bot;
			ST_CMP: begin
				// hold the bottom address so the read word stays put while stalled
				rd_addr            = addr_bot;
				emit               = differ;
				tok.token_kind     = TOK_CELL;
				tok.skip_count     = run_q;
				tok.top_color      = top_d_q;
				tok.bottom_color   = bot_d;
				tok_last           = !row_end;
			end
			ST_ROWEND: begin
				emit           = 1'b1;
				tok.token_kind = TOK_MOVE;
				tok.cursor_row = last_row ? 7'd0 : 7'(scan_row_q) + 7'd2;
				tok_last       = !last_row;
			end
			ST_FRAME: begin
				emit           = 1'b1;
				tok.token_kind = TOK_DONE;
				tok_last       = 1'b1;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			draw_sel_q  <= 1'b0;
			scan_col_q  <= '0;
			scan_row_q  <= '0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit && slot_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;

			case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (&cnt_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (!q_empty) begin
						case (q_cmd.kind)
							CMD_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_CLEAR;
							end
							CMD_PRESENT: begin
								scan_row_q <= row_clamp;
								if (9'(scan_col_q) < dims.width) state_q <= ST_TOP;
								else state_q <= ST_ROWEND;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (&cnt_q) state_q <= ST_CLRTOK;
				end
				ST_CLRTOK: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				ST_TOP: state_q <= ST_BOT;
				ST_BOT: state_q <= ST_CMP;
				ST_CMP: begin
					if (!differ || slot_free) begin
						if (differ) run_q <= '0;
						else if (run_q != 8'hFF) run_q <= run_q + 8'd1;
						scan_col_q <= XW'(col_next);
						state_q    <= row_end ? ST_ROWEND : ST_IDLE;
					end
				end
				ST_ROWEND: begin
					if (slot_free) begin
						scan_col_q <= '0;
						run_q      <= '0;
						if (last_row) state_q <= ST_FRAME;
						else begin
							scan_row_q <= scan_row_q + 1'b1;
							state_q    <= ST_IDLE;
						end
					end
				end
				ST_FRAME: begin
					if (slot_free) begin
						draw_sel_q <= !draw_sel_q;
						scan_row_q <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit && slot_free) begin
			out_tok_q  <= tok;
			out_last_q <= tok_last;
		end
		// capture the top pair while the bottom read is under way
		if (state_q == ST_BOT) begin
			top_d_q <= draw_sel_q ? rd_a_q : rd_b_q;
			top_o_q <= draw_sel_q ? rd_b_q : rd_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we_a) mem_a[wr_addr] <= wr_data;
		rd_a_q <= mem_a[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (we_b) mem_b[wr_addr] <= wr_data;
		rd_b_q <= mem_b[rd_addr];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_tok_q.cursor_row, out_tok_q.bottom_color,
	                   out_tok_q.top_color, out_tok_q.skip_count};
	assign m_tuser  = out_tok_q.token_kind;
	assign m_tlast  = out_last_q;

endmodule

>>> sv/half_block_frame_delta_encoder.sv
// Double-buffered frame store that turns each presented character cell (a vertical pixel
// pair) into delta tokens. The front classifies input words and queues up to four
// commands; the back owns both frame memories. A pixel write is made in the back's idle
// state as the command is popped. A present steps through the queue pop, two reads (top
// then bottom address, one read port per memory) and the compare that may emit the cell
// token; a row end adds a cursor-move step and a frame end a frame-done step after it.
// When the scan column lies past a shrunk width, the reads and the compare are skipped,
// and any step that emits a token waits while the output stalls. A clear sweeps all
// 2**(x bits + y bits) entries of the drawing buffer (32768 at the default sizes), one
// entry a cycle, then emits the cursor-home token. After reset both buffers are swept
// the same way, and no input word is taken until that pass is done; configuration writes
// are taken at any time.
module half_block_frame_delta_encoder #(
	parameter int MAX_WIDTH     = hbfd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_CHAR_ROWS = hbfd_pkg::DEF_MAX_CHAR_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // pos_x[12:0], pos_y[25:13], pixel_color[33:26]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // skip_count[7:0], top_color[15:8], bottom_color[23:16],
	                               // cursor_row[30:24]
	output logic [1:0]  m_tuser,   // token_kind[1:0]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);
	import hbfd_pkg::*;

	localparam int AW = col_bits(MAX_WIDTH) + y_bits(MAX_CHAR_ROWS);
	localparam int QW = $bits(cmd_t) + AW;

	logic          init_busy;
	logic          q_full;
	logic          q_empty;
	logic          push;
	logic          pop;
	cmd_t          push_cmd;
	logic [AW-1:0] push_addr;
	cmd_t          head_cmd;
	logic [AW-1:0] head_addr;
	logic [QW-1:0] head_data;
	dims_t         dims;

	hbfd_front #(
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_CHAR_ROWS (MAX_CHAR_ROWS),
		.AW            (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.init_busy (init_busy),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_addr (push_addr),
		.dims      (dims)
	);

	hbfd_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_addr, push_cmd}),
		.full      (q_full),
		.pop       (pop),
		.head_data (head_data),
		.empty     (q_empty)
	);

	assign head_cmd  = cmd_t'(head_data[$bits(cmd_t)-1:0]);
	assign head_addr = head_data[QW-1:$bits(cmd_t)];

	hbfd_back #(
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_CHAR_ROWS (MAX_CHAR_ROWS),
		.AW            (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dims      (dims),
		.q_empty   (q_empty),
		.q_cmd     (head_cmd),
		.q_addr    (head_addr),
		.pop       (pop),
		.init_busy (init_busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
